[sv/ste_pkg.sv]
`default_nettype none

package ste_pkg;

  // Default table size
  localparam int unsigned SLOTS_DEF = 8;

  // Raw times below this count as unknown
  localparam logic [31:0] TIME_VALID_MIN = 32'd1700000000;
  localparam logic [16:0] DAY_SECONDS    = 17'd86400;

  // Session length register
  localparam logic [8:0] DAYS_RESET = 9'd30;
  localparam logic [8:0] DAYS_MIN   = 9'd1;
  localparam logic [8:0] DAYS_MAX   = 9'd365;

  // Operation codes; 5 to 7 are no-ops
  typedef enum logic [2:0] {
    OP_CREATE     = 3'd0,
    OP_FIND       = 3'd1,
    OP_REVOKE     = 3'd2,
    OP_REVOKE_ALL = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input transfer
    logic dispatch;   // apply revoke operations
    logic issue;      // read entry at scan pointer, advance
    logic rd_idx;     // read entry at requested slot
    logic write_new;  // write the new session entry
    logic finish;     // load the result register
  } ste_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       scan_last;
    logic       out_free;
  } ste_sts_t;

endpackage

`default_nettype wire

[sv/ste_if.sv]
`default_nettype none

// Request channel
interface ste_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] digest_word_0;
  logic [63:0] digest_word_1;
  logic [63:0] digest_word_2;
  logic [63:0] digest_word_3;
  logic [2:0]  slot_index;
  logic [31:0] time_now;

  modport source (
    output valid, operation, digest_word_0, digest_word_1, digest_word_2,
           digest_word_3, slot_index, time_now,
    input  ready
  );
  modport sink (
    input  valid, operation, digest_word_0, digest_word_1, digest_word_2,
           digest_word_3, slot_index, time_now,
    output ready
  );
endinterface

// Response channel
interface ste_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [2:0]  slot;
  logic        entry_valid;
  logic [31:0] entry_created;
  logic [31:0] entry_expires;
  logic [3:0]  active_count;

  modport source (
    output valid, found, slot, entry_valid, entry_created, entry_expires,
           active_count,
    input  ready
  );
  modport sink (
    input  valid, found, slot, entry_valid, entry_created, entry_expires,
           active_count,
    output ready
  );
endinterface

`default_nettype wire

[sv/ste_ram.sv]
`default_nettype none

module ste_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic [WIDTH-1:0]        wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic      [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/ste_datapath.sv]
`default_nettype none

module ste_datapath import ste_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  input  wire ste_cmd_t    cmd_i,
  output ste_sts_t         sts_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [63:0] digest_word_0_i,
  input  wire logic [63:0] digest_word_1_i,
  input  wire logic [63:0] digest_word_2_i,
  input  wire logic [63:0] digest_word_3_i,
  input  wire logic [2:0]  slot_index_i,
  input  wire logic [31:0] time_now_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic             found_o,
  output logic [2:0]       slot_o,
  output logic             entry_valid_o,
  output logic [31:0]      entry_created_o,
  output logic [31:0]      entry_expires_o,
  output logic [3:0]       active_count_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  // Session length register
  logic [8:0]  days_q;
  logic [8:0]  days_lim;

  // Captured request
  logic [2:0]   op_q;
  logic [255:0] dig_q;
  logic [2:0]   idx_q;
  logic [31:0]  now_q;
  logic [25:0]  span_q;
  logic [31:0]  now_d;
  logic [25:0]  span_d;

  // Slot-index handling
  logic [SW+2:0] idx_ext;
  logic          idx_ok;
  logic [SW-1:0] idx_a;

  // Scan and evaluation
  logic [SW-1:0] scan_q;
  logic          eval_v_q;
  logic [SW-1:0] eval_idx_q;
  logic          got_q;
  logic [SW-1:0] free_q;
  logic [SW-1:0] old_q;
  logic [31:0]   min_q;
  logic          hit_q;
  logic          res_found_q;
  logic [SW-1:0] res_slot_q;
  logic [SW-1:0] sel_slot;
  logic [SW+2:0] slot_ext;

  // Table state
  logic [SLOTS-1:0] live_q, live_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW+3:0]    cnt_ext;

  // Memory ports
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [255:0]  dig_rdata;
  logic [63:0]   tim_rdata;
  logic [31:0]   exp_new;
  logic [31:0]   cr_t, ex_t;
  logic          live_e, expd, match;

  // Result register
  logic        out_valid_q;
  logic        found_q;
  logic [2:0]  slot_q;
  logic        ev_q;
  logic [31:0] ec_q;
  logic [31:0] ee_q;
  logic [3:0]  ac_q;

  // Clamp the configured days into range
  always_comb begin
    if (days_q < DAYS_MIN) begin
      days_lim = DAYS_MIN;
    end else if (days_q > DAYS_MAX) begin
      days_lim = DAYS_MAX;
    end else begin
      days_lim = days_q;
    end
  end

  assign now_d  = (time_now_i >= TIME_VALID_MIN) ? time_now_i : '0;
  assign span_d = 26'(days_lim) * 26'(DAY_SECONDS);

  assign idx_ext = {{SW{1'b0}}, idx_q};
  assign idx_ok  = idx_ext < (SW + 3)'(SLOTS);
  assign idx_a   = idx_ext[SW-1:0];

  // Entry fields returned from the scan
  assign cr_t   = tim_rdata[63:32];
  assign ex_t   = tim_rdata[31:0];
  assign live_e = live_q[eval_idx_q];
  assign expd   = (now_q != '0) && (ex_t != '0) && (now_q > ex_t);
  assign match  = (dig_rdata == dig_q);

  assign sel_slot = got_q ? free_q : old_q;
  assign exp_new  = (now_q != '0) ? (now_q + 32'(span_q)) : '0;

  assign rd_en   = cmd_i.issue | (cmd_i.rd_idx & idx_ok);
  assign rd_addr = cmd_i.issue ? scan_q : idx_a;

  ste_ram #(.WIDTH(256), .DEPTH(SLOTS)) u_dig_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_new),
    .waddr_i (sel_slot),
    .wdata_i (dig_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (dig_rdata)
  );

  ste_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_tim_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_new),
    .waddr_i (sel_slot),
    .wdata_i ({now_q, exp_new}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (tim_rdata)
  );

  // Valid marks and live count; at most one kind of update per cycle
  always_comb begin
    live_d = live_q;
    cnt_d  = cnt_q;
    if (eval_v_q && live_e && expd) begin
      if (op_q == OP_CREATE || (op_q == OP_FIND && !hit_q && match)) begin
        live_d[eval_idx_q] = 1'b0;
        cnt_d              = cnt_d - 1'b1;
      end
    end
    if (cmd_i.write_new) begin
      if (!live_q[sel_slot]) begin
        cnt_d = cnt_d + 1'b1;
      end
      live_d[sel_slot] = 1'b1;
    end
    if (cmd_i.dispatch) begin
      case (op_q)
        OP_REVOKE: begin
          if (idx_ok && live_q[idx_a]) begin
            live_d[idx_a] = 1'b0;
            cnt_d         = cnt_d - 1'b1;
          end
        end
        OP_REVOKE_ALL: begin
          live_d = '0;
          cnt_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      days_q      <= DAYS_RESET;
      live_q      <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      eval_v_q    <= 1'b0;
      got_q       <= 1'b0;
      hit_q       <= 1'b0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        days_q <= cfg_wdata_i;
      end
      live_q   <= live_d;
      cnt_q    <= cnt_d;
      eval_v_q <= cmd_i.issue;
      if (cmd_i.load) begin
        scan_q      <= '0;
        got_q       <= 1'b0;
        hit_q       <= 1'b0;
        res_found_q <= 1'b0;
      end
      if (cmd_i.issue) begin
        scan_q <= scan_q + 1'b1;
      end
      // first free slot after purge
      if (eval_v_q && op_q == OP_CREATE && !got_q && (!live_e || expd)) begin
        got_q <= 1'b1;
      end
      // first live digest match ends the search
      if (eval_v_q && op_q == OP_FIND && !hit_q && live_e && match) begin
        hit_q <= 1'b1;
        if (!expd) begin
          res_found_q <= 1'b1;
        end
      end
      if (cmd_i.write_new) begin
        res_found_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      dig_q  <= {digest_word_3_i, digest_word_2_i, digest_word_1_i, digest_word_0_i};
      idx_q  <= slot_index_i;
      now_q  <= now_d;
      span_q <= span_d;
    end
    if (cmd_i.issue) begin
      eval_idx_q <= scan_q;
    end
    // oldest entry, lowest index on a tie
    if (eval_v_q && op_q == OP_CREATE) begin
      if (!got_q && (!live_e || expd)) begin
        free_q <= eval_idx_q;
      end
      if (eval_idx_q == '0 || cr_t < min_q) begin
        min_q <= cr_t;
        old_q <= eval_idx_q;
      end
    end
    if (eval_v_q && op_q == OP_FIND && !hit_q && live_e && match && !expd) begin
      res_slot_q <= eval_idx_q;
    end
    if (cmd_i.write_new) begin
      res_slot_q <= sel_slot;
    end
    if (cmd_i.finish) begin
      found_q <= res_found_q;
      slot_q  <= res_found_q ? slot_ext[2:0] : 3'd0;
      ac_q    <= (cnt_ext > (CW + 4)'(15)) ? 4'hF : cnt_ext[3:0];
      if (op_q == OP_READ && idx_ok) begin
        ev_q <= live_q[idx_a];
        ec_q <= tim_rdata[63:32];
        ee_q <= tim_rdata[31:0];
      end else begin
        ev_q <= 1'b0;
        ec_q <= '0;
        ee_q <= '0;
      end
    end
  end

  assign slot_ext = {3'b000, res_slot_q};
  assign cnt_ext  = {4'b0000, cnt_q};

  assign sts_o.op        = op_q;
  assign sts_o.scan_last = (scan_q == LAST_SLOT);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign slot_o          = slot_q;
  assign entry_valid_o   = ev_q;
  assign entry_created_o = ec_q;
  assign entry_expires_o = ee_q;
  assign active_count_o  = ac_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("live count above table size");

  a_write_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |-> !eval_v_q)
    else $error("new entry written while scan still evaluating");

  a_eval_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_v_q |-> (op_q == OP_CREATE || op_q == OP_FIND))
    else $error("scan evaluation for an operation without scan");

endmodule

`default_nettype wire

[sv/ste_ctrl.sv]
`default_nettype none

module ste_ctrl import ste_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ste_sts_t sts_i,
  output ste_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_READ,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        case (sts_i.op)
          OP_CREATE, OP_FIND: state_d = S_SCAN;
          OP_READ:            state_d = S_READ;
          default:            state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = (sts_i.op == OP_CREATE) ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        cmd_o.write_new = 1'b1;
        state_d         = S_DONE;
      end
      S_READ: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while previous one in work");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free)
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

[sv/session_table_with_expiry_core.sv]
// Session table with expiry: SLOTS entries of 256-bit digest, creation time,
// expiry time and valid mark. One request is in work at a time. Create and
// find scan the table one entry per cycle through the single read port of
// the entry memories. A finished result sits in an output register, and the
// next request is taken from the cycle after it is loaded, while it waits.
// session_days is written through cfg_we_i; the user must write it only
// while no request is in work, as the block itself does not enforce this.
// Values outside 1..365 are clamped.
`default_nettype none

module session_table_with_expiry_core import ste_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i,
  ste_in_if.sink          in_ch,
  ste_out_if.source       out_ch
);

  ste_cmd_t cmd;
  ste_sts_t sts;
  logic     in_ready;

  // Sequencer
  ste_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Table, scan logic and result register
  ste_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (in_ch.operation),
    .digest_word_0_i (in_ch.digest_word_0),
    .digest_word_1_i (in_ch.digest_word_1),
    .digest_word_2_i (in_ch.digest_word_2),
    .digest_word_3_i (in_ch.digest_word_3),
    .slot_index_i    (in_ch.slot_index),
    .time_now_i      (in_ch.time_now),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .found_o         (out_ch.found),
    .slot_o          (out_ch.slot),
    .entry_valid_o   (out_ch.entry_valid),
    .entry_created_o (out_ch.entry_created),
    .entry_expires_o (out_ch.entry_expires),
    .active_count_o  (out_ch.active_count)
  );

endmodule

`default_nettype wire
